### design/rmq_pkg.sv
// rmq_pkg: request/result types, widths and axis codes for the
// rotation matrix to quaternion pipeline; no dependencies
package rmq_pkg;

  // fixed point widths
  localparam int unsigned MatW  = 16;   // Q2.14 entries and results
  localparam int unsigned DW    = 18;   // sums and differences of two entries
  localparam int unsigned RadW  = 48;   // radicand scaled by 2^30
  localparam int unsigned RootW = 24;   // square root, Q22
  localparam int unsigned QuoW  = 17;   // quotient bits kept before saturation
  localparam int unsigned RemW  = 41;   // divider remainder width

  localparam int unsigned NumSqrt = RootW;  // one root bit per stage
  localparam int unsigned NumDiv  = QuoW;   // one quotient bit per stage

  // which output carries the square root term
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;
  localparam logic [1:0] AX_W = 2'd3;

  typedef struct packed {
    logic signed [MatW-1:0] r0c0;
    logic signed [MatW-1:0] r0c1;
    logic signed [MatW-1:0] r0c2;
    logic signed [MatW-1:0] r1c0;
    logic signed [MatW-1:0] r1c1;
    logic signed [MatW-1:0] r1c2;
    logic signed [MatW-1:0] r2c0;
    logic signed [MatW-1:0] r2c1;
    logic signed [MatW-1:0] r2c2;
  } rmq_in_t;

  typedef struct packed {
    logic signed [MatW-1:0] quat_x;
    logic signed [MatW-1:0] quat_y;
    logic signed [MatW-1:0] quat_z;
    logic signed [MatW-1:0] quat_w;
  } rmq_out_t;

  // square root stage contents
  typedef struct packed {
    logic [RadW-1:0]       rem;
    logic [RootW-1:0]      root;
    logic [1:0]            axis;
    logic [2:0][DW-1:0]    d;
  } rmq_sq_t;

  // one divider lane
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] quo;
    logic            neg;
    logic            ovf;
    logic            zero;
  } rmq_lane_t;

  // divider stage contents
  typedef struct packed {
    logic [RootW-1:0]     root;
    logic [MatW-1:0]      big;
    logic [1:0]           axis;
    rmq_lane_t [2:0]      lane;
  } rmq_dv_t;

endpackage

### design/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: pipelined conversion of a Q2.14 rotation
// matrix into a Q2.14 unit quaternion; depends on rmq_pkg
//
// Usage
//   Request channel: valid_i / stall_o / data_i carries the nine matrix
//   entries. A request is taken at a rising edge with valid_i high and
//   stall_o low. Result channel: valid_o / stall_i / data_o carries quat_x,
//   quat_y, quat_z, quat_w; a result is taken when valid_o is high and
//   stall_i is low.
//   From request to result an item passes a first stage that picks the
//   branch and forms the radicand, 24 square root stages (one root bit each),
//   one divider setup stage, 17 divider stages (one quotient bit each, three
//   lanes side by side) and one output register.
//   One request per cycle while stall_i is low; every stage holds one item.
//   Reset clears all valid bits; no result is pending after it.
//   When the receiver stalls, the output register holds its result and the
//   stages behind it keep filling empty slots; stall_o rises only once every
//   stage holds an item.
module rotation_matrix_to_quaternion (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  rmq_pkg::rmq_in_t data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output rmq_pkg::rmq_out_t data_o
);
  import rmq_pkg::*;

  localparam int unsigned SqBase = 0;               // stage 0 plus root stages
  localparam int unsigned DvBase = NumSqrt + 1;     // divider setup stage
  localparam int unsigned OutStg = DvBase + NumDiv + 1;
  localparam int unsigned NSt    = OutStg + 1;

  logic [NSt-1:0] vld_q;
  logic [NSt:0]   rdy;

  rmq_sq_t  sq_q [NumSqrt+1];
  rmq_dv_t  dv_q [NumDiv+1];
  rmq_out_t out_q;

  // ready chain: a stage may load when it is empty or moving on
  always_comb begin
    rdy[NSt] = !stall_i;
    for (int k = NSt - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign stall_o = !rdy[0];
  assign valid_o = vld_q[OutStg];
  assign data_o  = out_q;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < NSt; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 0: branch select, radicand and the three quotient numerators
  function automatic logic signed [18:0] sx(input logic signed [MatW-1:0] a);
    return 19'(a);
  endfunction

  rmq_sq_t s0_d;
  always_comb begin
    logic signed [18:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [18:0] rad, r, d0, d1, d2;
    logic [1:0]         ax;
    m00 = sx(data_i.r0c0); m01 = sx(data_i.r0c1); m02 = sx(data_i.r0c2);
    m10 = sx(data_i.r1c0); m11 = sx(data_i.r1c1); m12 = sx(data_i.r1c2);
    m20 = sx(data_i.r2c0); m21 = sx(data_i.r2c1); m22 = sx(data_i.r2c2);
    rad = 19'sd16384 + m00 + m11 + m22;
    if (rad > 0) begin
      ax = AX_W; r = rad;
      d0 = m21 - m12; d1 = m02 - m20; d2 = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      ax = AX_X; r = 19'sd16384 + m00 - m11 - m22;
      d0 = m01 + m10; d1 = m02 + m20; d2 = m21 - m12;
    end else if (m11 > m22) begin
      ax = AX_Y; r = 19'sd16384 + m11 - m00 - m22;
      d0 = m01 + m10; d1 = m12 + m21; d2 = m02 - m20;
    end else begin
      ax = AX_Z; r = 19'sd16384 + m22 - m00 - m11;
      d0 = m02 + m20; d1 = m12 + m21; d2 = m10 - m01;
    end
    // negative radicand clamps to zero
    if (r <= 0) begin
      r = '0;
    end
    s0_d.rem  = {1'b0, r[16:0], 30'b0};
    s0_d.root = '0;
    s0_d.axis = ax;
    s0_d.d[0] = d0[DW-1:0];
    s0_d.d[1] = d1[DW-1:0];
    s0_d.d[2] = d2[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[SqBase]) begin
      sq_q[0] <= s0_d;
    end
  end

  // square root stages, one result bit each, most significant first
  for (genvar s = 1; s <= NumSqrt; s++) begin : g_sqrt
    localparam int unsigned Bit = NumSqrt - s;
    rmq_sq_t sq_d;
    always_comb begin
      logic [RadW-1:0] trial;
      trial = (RadW'(sq_q[s-1].root) << (Bit + 1)) + (RadW'(1) << (2 * Bit));
      sq_d = sq_q[s-1];
      if (sq_q[s-1].rem >= trial) begin
        sq_d.rem       = sq_q[s-1].rem - trial;
        sq_d.root[Bit] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[SqBase + s]) begin
        sq_q[s] <= sq_d;
      end
    end
  end

  // divider setup: rounding bias, overflow check, root term
  rmq_dv_t dv0_d;
  always_comb begin
    logic [RootW:0]  bigw;
    logic [RemW-1:0] lim;
    logic [DW-1:0]   dv;
    logic [QuoW-1:0] mag;
    bigw = ({1'b0, sq_q[NumSqrt].root} + (RootW+1)'(256)) >> 9;
    dv0_d.root = sq_q[NumSqrt].root;
    dv0_d.axis = sq_q[NumSqrt].axis;
    dv0_d.big  = (bigw > (RootW+1)'(32767)) ? 16'sd32767 : bigw[MatW-1:0];
    lim = RemW'(sq_q[NumSqrt].root) << QuoW;
    for (int l = 0; l < 3; l++) begin
      dv  = sq_q[NumSqrt].d[l];
      mag = dv[DW-1] ? QuoW'(-dv) : dv[QuoW-1:0];
      dv0_d.lane[l].rem  = (RemW'(mag) << 21) + RemW'(sq_q[NumSqrt].root >> 1);
      dv0_d.lane[l].quo  = '0;
      dv0_d.lane[l].neg  = dv[DW-1];
      dv0_d.lane[l].zero = (mag == '0);
      dv0_d.lane[l].ovf  = dv0_d.lane[l].rem >= lim;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[DvBase]) begin
      dv_q[0] <= dv0_d;
    end
  end

  // restoring divider stages, three lanes in parallel
  for (genvar j = 1; j <= NumDiv; j++) begin : g_div
    localparam int unsigned Bit = NumDiv - j;
    rmq_dv_t dv_d;
    always_comb begin
      logic [RemW-1:0] trial;
      trial = RemW'(dv_q[j-1].root) << Bit;
      dv_d = dv_q[j-1];
      for (int l = 0; l < 3; l++) begin
        if (dv_q[j-1].lane[l].rem >= trial) begin
          dv_d.lane[l].rem      = dv_q[j-1].lane[l].rem - trial;
          dv_d.lane[l].quo[Bit] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[DvBase + j]) begin
        dv_q[j] <= dv_d;
      end
    end
  end

  // saturate quotients and place components by axis
  function automatic logic [MatW-1:0] fmt(input rmq_lane_t ln);
    logic [MatW-1:0] res;
    if (ln.zero) begin
      res = '0;
    end else if (ln.ovf) begin
      res = ln.neg ? 16'h8000 : 16'h7fff;
    end else if (ln.neg) begin
      res = (ln.quo > QuoW'(32768)) ? 16'h8000 : MatW'(-ln.quo);
    end else begin
      res = (ln.quo > QuoW'(32767)) ? 16'h7fff : ln.quo[MatW-1:0];
    end
    return res;
  endfunction

  rmq_out_t out_d;
  always_comb begin
    logic [MatW-1:0] l0, l1, l2, bg;
    l0 = fmt(dv_q[NumDiv].lane[0]);
    l1 = fmt(dv_q[NumDiv].lane[1]);
    l2 = fmt(dv_q[NumDiv].lane[2]);
    bg = dv_q[NumDiv].big;
    case (dv_q[NumDiv].axis)
      AX_X: begin
        out_d = '{quat_x: bg, quat_y: l0, quat_z: l1, quat_w: l2};
      end
      AX_Y: begin
        out_d = '{quat_x: l0, quat_y: bg, quat_z: l1, quat_w: l2};
      end
      AX_Z: begin
        out_d = '{quat_x: l0, quat_y: l1, quat_z: bg, quat_w: l2};
      end
      default: begin
        out_d = '{quat_x: l0, quat_y: l1, quat_z: l2, quat_w: bg};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[OutStg]) begin
      out_q <= out_d;
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for rotation_matrix_to_quaternion, random and
// directed matrices checked against an in-bench quaternion predictor; needs rmq_pkg
module tb_top;
  import rmq_pkg::*;

  // predicted quaternions in request order, checked as results come out
  class quat_board;
    rmq_out_t pending[$];
    int errors = 0;

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic signed [15:0] sat(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function longint unsigned root_of(longint rad);
      if (rad <= 0) return 0;
      return isqrt(longint'(rad) << 30);
    endfunction

    function logic signed [15:0] quot(longint d, longint unsigned rt);
      longint unsigned mag, q;
      if (rt == 0) return d > 0 ? 16'sh7fff : (d < 0 ? 16'sh8000 : 16'sh0);
      mag = d < 0 ? -d : d;
      q = ((mag << 21) + rt / 2) / rt;
      if (q > 65536) q = 65536;
      return sat(d < 0 ? -longint'(q) : longint'(q));
    endfunction

    function logic signed [15:0] big(longint unsigned rt);
      return sat(longint'((rt + 256) >> 9));
    endfunction

    function void note_request(rmq_in_t m);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22, rad;
      longint unsigned rt;
      rmq_out_t q;
      a00 = m.r0c0; a01 = m.r0c1; a02 = m.r0c2;
      a10 = m.r1c0; a11 = m.r1c1; a12 = m.r1c2;
      a20 = m.r2c0; a21 = m.r2c1; a22 = m.r2c2;
      rad = 16384 + a00 + a11 + a22;
      if (rad > 0) begin
        rt = root_of(rad);
        q.quat_w = big(rt);
        q.quat_x = quot(a21 - a12, rt);
        q.quat_y = quot(a02 - a20, rt);
        q.quat_z = quot(a10 - a01, rt);
      end else if (a00 > a11 && a00 > a22) begin
        rt = root_of(16384 + a00 - a11 - a22);
        q.quat_x = big(rt);
        q.quat_y = quot(a01 + a10, rt);
        q.quat_z = quot(a02 + a20, rt);
        q.quat_w = quot(a21 - a12, rt);
      end else if (a11 > a22) begin
        rt = root_of(16384 + a11 - a00 - a22);
        q.quat_x = quot(a01 + a10, rt);
        q.quat_y = big(rt);
        q.quat_z = quot(a12 + a21, rt);
        q.quat_w = quot(a02 - a20, rt);
      end else begin
        rt = root_of(16384 + a22 - a00 - a11);
        q.quat_x = quot(a02 + a20, rt);
        q.quat_y = quot(a12 + a21, rt);
        q.quat_z = big(rt);
        q.quat_w = quot(a10 - a01, rt);
      end
      pending.push_back(q);
    endfunction

    function void check_result(rmq_out_t got);
      rmq_out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.quat_x !== exp.quat_x) begin
        $display("%0t: quat_x exp %0d got %0d", $time, exp.quat_x, got.quat_x);
        errors++;
      end
      if (got.quat_y !== exp.quat_y) begin
        $display("%0t: quat_y exp %0d got %0d", $time, exp.quat_y, got.quat_y);
        errors++;
      end
      if (got.quat_z !== exp.quat_z) begin
        $display("%0t: quat_z exp %0d got %0d", $time, exp.quat_z, got.quat_z);
        errors++;
      end
      if (got.quat_w !== exp.quat_w) begin
        $display("%0t: quat_w exp %0d got %0d", $time, exp.quat_w, got.quat_w);
        errors++;
      end
    endfunction
  endclass

  localparam int NumRandom = 1600;
  localparam int CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  rmq_in_t data_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  rmq_out_t data_o;

  quat_board board = new();
  bit hold_off = 1'b0;
  bit sending_done = 1'b0;
  int cycle_count = 0;

  rotation_matrix_to_quaternion u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .data_i(data_i), .valid_o(valid_o), .stall_i(stall_i), .data_o(data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("rotation_matrix_to_quaternion verification failed");
      $finish;
    end
  end

  // accept results and check them
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) board.check_result(data_o);
  end

  // receiver stall pattern, with one long hold-off early on
  initial begin
    int gap;
    @(posedge rst_ni);
    repeat (60) @(posedge clk_i);
    stall_i <= 1'b1;
    hold_off = 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off = 1'b0;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      if ((cycle_count / 2000) % 2 == 1) gap = 0;
      stall_i <= (gap != 0);
      repeat (gap) @(posedge clk_i);
      stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  // offer one request and wait for it to be taken
  task automatic send_request(rmq_in_t m, bit may_idle);
    int gap;
    gap = may_idle ? $urandom_range(0, 3) : 0;
    if ((cycle_count / 2000) % 2 == 1) gap = 0;
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    data_i <= m;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    board.note_request(m);
  endtask

  function automatic rmq_in_t diag(int a, int b, int c);
    rmq_in_t m;
    m = '0;
    m.r0c0 = 16'(a); m.r1c1 = 16'(b); m.r2c2 = 16'(c);
    return m;
  endfunction

  // random entry, weighted to extremes and to the unit range
  function automatic logic signed [15:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return 16'($urandom());
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  initial begin
    rmq_in_t m;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity, each fallback axis, ties, zero radicand, extremes
    send_request(diag(16384, 16384, 16384), 0);
    send_request(diag(16384, -16384, -16384), 1);
    send_request(diag(-16384, 16384, -16384), 1);
    send_request(diag(-16384, -16384, 16384), 1);
    send_request(diag(-8192, -8192, -8192), 1);
    send_request(diag(-16384, -16384, -16384), 1);
    send_request(diag(-32768, -32768, -32768), 1);
    send_request(diag(32767, 32767, 32767), 1);
    send_request(diag(-16384, -16384, 0), 1);
    m = diag(-30000, -30000, -30000);
    m.r0c1 = 32767; m.r1c0 = 32767; m.r0c2 = -32768; m.r2c0 = -32768;
    send_request(m, 1);
    m = diag(-20000, -20000, -20000);
    m.r2c1 = 32767; m.r1c2 = -32768;
    send_request(m, 1);
    m = '1;
    send_request(m, 1);
    m = {9{16'sh7fff}};
    send_request(m, 1);
    m = {9{16'sh8000}};
    send_request(m, 1);
    m = diag(16384, 16384, 16384);
    m.r2c1 = 32767; m.r1c2 = -32768; m.r0c2 = -32768; m.r2c0 = 32767;
    m.r1c0 = 32767; m.r0c1 = -32768;
    send_request(m, 1);

    // random matrices, entries mostly in the unit range, with extremes and noise
    for (int n = 0; n < NumRandom; n++) begin
      m.r0c0 = rand_entry(); m.r0c1 = rand_entry(); m.r0c2 = rand_entry();
      m.r1c0 = rand_entry(); m.r1c1 = rand_entry(); m.r1c2 = rand_entry();
      m.r2c0 = rand_entry(); m.r2c1 = rand_entry(); m.r2c2 = rand_entry();
      if ($urandom_range(0, 2) == 0) begin
        // push toward a negative trace so the fallback axes are taken
        m.r0c0 = -$signed({1'b0, 15'($urandom_range(0, 16384))});
        m.r1c1 = -$signed({1'b0, 15'($urandom_range(0, 16384))});
        m.r2c2 = $urandom_range(0, 1) ? m.r1c1 : 16'($urandom_range(0, 16384));
      end
      send_request(m, 1);
    end
    valid_i <= 1'b0;
    sending_done = 1'b1;

    while (board.pending.size() != 0 || hold_off) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("rotation_matrix_to_quaternion verification clean");
    end else begin
      $display("rotation_matrix_to_quaternion verification failed");
    end
    $finish;
  end
endmodule
